FILE: rtl/core/pida_pkg.sv
// Package for the positional insert/delete list: payload structs, codes,
// controller state type and default parameter values. No dependencies.
package pida_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MODE_W   = 2;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [POS_W-1:0]         entry_count;
        logic signed [WORD_W-1:0] read_value;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the input word
        logic exec;   // apply the operation and load the output register
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

FILE: rtl/core/pida_ctrl.sv
// Controller for the positional insert/delete list: input handshake, sequencing
// and output valid. Depends on pida_pkg.
module pida_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pida_pkg::t_cmd o_cmd
);

    pida_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pida_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            pida_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pida_pkg::ST_EXEC;
                end
            end
            pida_pkg::ST_EXEC: begin
                // wait until the output register is free or drains this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = pida_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pida_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/pida_datapath.sv
// Datapath for the positional insert/delete list: input register, row of
// shifting cells, entry count, checks and output register. Depends on pida_pkg.
module pida_datapath #(
    parameter int DEPTH      = pida_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pida_pkg::DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pida_pkg::t_cmd      i_cmd,
    input  pida_pkg::t_in_word  i_in_data,
    output pida_pkg::t_out_word o_out_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int PW   = pida_pkg::POS_W;
    localparam int OW   = pida_pkg::WORD_W;
    localparam int CMPW = (CW > PW) ? CW : PW;

    pida_pkg::t_in_word  r_in;
    pida_pkg::t_out_word r_out;
    logic [CW-1:0]         r_count, n_count;
    logic [DATA_WIDTH-1:0] r_cells [DEPTH];

    logic [CMPW-1:0]              pos_ext, cnt_ext, ncnt_ext;
    logic [AW-1:0]                pos_idx;
    logic                         is_full, is_empty;
    logic                         do_ins, do_del, do_rd;
    logic [pida_pkg::STATUS_W-1:0] status;
    logic [DATA_WIDTH-1:0]        ins_word, rd_word;
    logic [OW-1:0]                rd_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
    end

    assign pos_ext  = CMPW'(r_in.position);
    assign cnt_ext  = CMPW'(r_count);
    assign pos_idx  = pos_ext[AW-1:0];
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // full/empty take precedence over the position check
    always_comb begin
        status = pida_pkg::STATUS_OK;
        do_ins = 1'b0;
        do_del = 1'b0;
        do_rd  = 1'b0;
        unique case (r_in.mode)
            pida_pkg::MODE_INSERT: begin
                if (is_full) begin
                    status = pida_pkg::STATUS_FULL;
                end else if (pos_ext > cnt_ext) begin
                    status = pida_pkg::STATUS_RANGE;
                end else begin
                    do_ins = 1'b1;
                end
            end
            pida_pkg::MODE_DELETE, pida_pkg::MODE_READ: begin
                if (is_empty) begin
                    status = pida_pkg::STATUS_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status = pida_pkg::STATUS_RANGE;
                end else begin
                    do_rd  = 1'b1;
                    do_del = (r_in.mode == pida_pkg::MODE_DELETE);
                end
            end
            default: begin
                status = pida_pkg::STATUS_OK;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end
    end

    assign ncnt_ext = CMPW'(n_count);
    assign rd_word  = r_cells[pos_idx];

    // word width conversion in both directions
    generate
        if (DATA_WIDTH <= OW) begin : g_narrow
            assign ins_word = r_in.value[DATA_WIDTH-1:0];
            if (DATA_WIDTH == OW) begin : g_same
                assign rd_out = rd_word;
            end else begin : g_ext
                assign rd_out = {{(OW - DATA_WIDTH){rd_word[DATA_WIDTH-1]}}, rd_word};
            end
        end else begin : g_wide
            assign ins_word = {{(DATA_WIDTH - OW){r_in.value[OW-1]}}, r_in.value};
            assign rd_out   = rd_word[OW-1:0];
        end
    endgenerate

    // each cell looks only at its own neighbors
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            localparam logic [CMPW-1:0] IDX = CMPW'(g);
            if (g == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (i_cmd.exec) begin
                        if (do_ins && IDX == pos_ext) begin
                            r_cells[g] <= ins_word;
                        end else if (do_del && IDX >= pos_ext && g < DEPTH - 1) begin
                            r_cells[g] <= r_cells[(g + 1) % DEPTH];
                        end
                    end
                end
            end else if (g == DEPTH - 1) begin : g_last
                always_ff @(posedge i_clk) begin
                    if (i_cmd.exec && do_ins) begin
                        if (IDX == pos_ext) begin
                            r_cells[g] <= ins_word;
                        end else if (IDX > pos_ext) begin
                            r_cells[g] <= r_cells[g-1];
                        end
                    end
                end
            end else begin : g_mid
                always_ff @(posedge i_clk) begin
                    if (i_cmd.exec) begin
                        if (do_ins && IDX == pos_ext) begin
                            r_cells[g] <= ins_word;
                        end else if (do_ins && IDX > pos_ext) begin
                            r_cells[g] <= r_cells[g-1];
                        end else if (do_del && IDX >= pos_ext) begin
                            r_cells[g] <= r_cells[g+1];
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out.status      <= status;
            r_out.entry_count <= ncnt_ext[PW-1:0];
            r_out.read_value  <= do_rd ? rd_out : '0;
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: rtl/core/positional_insert_delete_array.sv
// Positional insert/delete list, top level: controller plus datapath.
// The accepting edge captures the input word in the input register; the execute
// step then applies the operation and loads the output register, raising output valid.
// One word is in flight at a time; the execute step waits while the output
// register holds a word not yet taken. The next input is taken after execute.
// Reset (i_rst_n low, synchronous): count cleared, no output pending.
// Cells are not cleared; only entries below the count are ever read.
module positional_insert_delete_array #(
    parameter int DEPTH      = pida_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pida_pkg::DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pida_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pida_pkg::t_out_word o_out_data
);

    pida_pkg::t_cmd cmd;

    pida_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    pida_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

FILE: rtl/core/pida_checker.sv
// Port-level checker for the positional insert/delete list, with its bind.
// Depends on pida_pkg and the top-level port list.
module pida_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input pida_pkg::t_in_word  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pida_pkg::t_out_word o_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed or dropped while stalled");

    // one word in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input accepted while previous word still executing");

    // with the output register empty at accept, execute does not stall and the result becomes valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !o_out_valid |=> ##1 o_out_valid)
        else $error("result not valid one cycle after accept");

    // errors never return data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != pida_pkg::STATUS_OK
        |-> o_out_data.read_value == '0)
        else $error("error result carries nonzero read value");

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/tb_positional_insert_delete_array.sv
// Self-checking testbench for positional_insert_delete_array: a shadow list predicts
// every result word, and directed and random operations run under varying back-pressure.
// Depends on pida_pkg and the positional_insert_delete_array RTL.
module tb_positional_insert_delete_array;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = pida_pkg::DEPTH_DEF;
    localparam int DW         = pida_pkg::DATA_WIDTH_DEF;
    localparam int POS_MAX    = (1 << pida_pkg::POS_W) - 1;
    localparam int CYCLE_MAX  = 200000;
    localparam logic [pida_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_out_ready = 1'b0;
    pida_pkg::t_in_word  i_in_data   = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    pida_pkg::t_out_word o_out_data;

    // shadow of the list
    logic [63:0] shadow_cells [DEPTH];
    int          shadow_count = 0;

    pida_pkg::t_out_word pending_results [$];
    pida_pkg::t_out_word want;
    int                  err_cnt       = 0;
    int                  in_idle_pct   = 0;
    int                  out_stall_pct = 0;
    int                  hold_left     = 0;
    int                  cycle_cnt     = 0;

    positional_insert_delete_array DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_MAX) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // stored cell keeps the low DW bits of the sign-extended value
    function automatic logic [63:0] to_cell(logic [pida_pkg::WORD_W-1:0] v);
        logic [63:0] c;
        c = {{32{v[pida_pkg::WORD_W-1]}}, v};
        for (int i = DW; i < 64; i++) c[i] = 1'b0;
        return c;
    endfunction

    function automatic logic [pida_pkg::WORD_W-1:0] from_cell(logic [63:0] c);
        logic [63:0] x;
        x = c;
        for (int i = DW; i < 64; i++) x[i] = c[DW-1];
        return x[pida_pkg::WORD_W-1:0];
    endfunction

    // apply one operation to the shadow list and return the result word it gives
    function automatic pida_pkg::t_out_word list_apply(pida_pkg::t_in_word w);
        pida_pkg::t_out_word r;
        int                  pos;
        r.status     = pida_pkg::STATUS_OK;
        r.read_value = '0;
        pos          = int'(w.position);
        case (w.mode)
            pida_pkg::MODE_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = pida_pkg::STATUS_FULL;
                end else if (pos > shadow_count) begin
                    r.status = pida_pkg::STATUS_RANGE;
                end else begin
                    for (int i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[pos] = to_cell(w.value);
                    shadow_count++;
                end
            end
            pida_pkg::MODE_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = pida_pkg::STATUS_EMPTY;
                end else if (pos >= shadow_count) begin
                    r.status = pida_pkg::STATUS_RANGE;
                end else begin
                    r.read_value = from_cell(shadow_cells[pos]);
                    for (int i = pos; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
                    shadow_count--;
                end
            end
            pida_pkg::MODE_READ: begin
                if (shadow_count == 0) begin
                    r.status = pida_pkg::STATUS_EMPTY;
                end else if (pos >= shadow_count) begin
                    r.status = pida_pkg::STATUS_RANGE;
                end else begin
                    r.read_value = from_cell(shadow_cells[pos]);
                end
            end
            default: ;
        endcase
        r.entry_count = pida_pkg::POS_W'(shadow_count);
        return r;
    endfunction

    function automatic pida_pkg::t_in_word make_word(logic [pida_pkg::MODE_W-1:0] mode, int pos,
                                                     logic [31:0] value);
        pida_pkg::t_in_word w;
        w.mode     = mode;
        w.position = pida_pkg::POS_W'(pos);
        w.value    = value;
        return w;
    endfunction

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(15) == 0) begin
            case ($urandom_range(3))
                0: v = 32'h7fff_ffff;
                1: v = 32'h8000_0000;
                2: v = 32'h0000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end
        return v;
    endfunction

    // mostly legal operations; grow selects an insert-heavy or delete-heavy mix
    function automatic pida_pkg::t_in_word rand_word(bit grow);
        int r;
        int last;
        last = (shadow_count > 0) ? shadow_count - 1 : 0;
        if ($urandom_range(99) < 12)
            return make_word(pida_pkg::MODE_W'($urandom_range(3)), $urandom_range(POS_MAX),
                             rand_value());
        r = $urandom_range(99);
        if (r < (grow ? 70 : 25))
            return make_word(pida_pkg::MODE_INSERT, $urandom_range(shadow_count), rand_value());
        if (r < (grow ? 90 : 85))
            return make_word(pida_pkg::MODE_DELETE, $urandom_range(last), rand_value());
        return make_word(pida_pkg::MODE_READ, $urandom_range(last), rand_value());
    endfunction

    task automatic send_word(input pida_pkg::t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(list_apply(w));
    endtask

    task automatic send_op(input logic [pida_pkg::MODE_W-1:0] mode, input int pos,
                           input logic [31:0] value);
        send_word(make_word(mode, pos, value));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic chk_field(input string name, input logic [31:0] exp_v, input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            err_cnt++;
        end
    endtask

    // result side: check every accepted word, then drive ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %p", $time, o_out_data);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                chk_field("status", 32'(want.status), 32'(o_out_data.status));
                chk_field("entry_count", 32'(want.entry_count), 32'(o_out_data.entry_count));
                chk_field("read_value", want.read_value, o_out_data.read_value);
            end
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic test_empty_list();
        send_op(pida_pkg::MODE_DELETE, 0, 32'h1234_5678);
        send_op(pida_pkg::MODE_READ, 0, 32'h0);
        send_op(pida_pkg::MODE_READ, POS_MAX, 32'hffff_ffff);  // empty wins over range
        send_op(pida_pkg::MODE_INSERT, 1, 32'h5555_aaaa);      // past the count
        send_op(MODE_UNUSED, 5, 32'hdead_beef);
        wait_drained();
    endtask

    task automatic test_edges();
        send_op(pida_pkg::MODE_INSERT, 0, 32'h7fff_ffff);
        send_op(pida_pkg::MODE_INSERT, 1, 32'h8000_0000);      // at the end
        send_op(pida_pkg::MODE_INSERT, 1, 32'h0000_0000);      // in the middle
        send_op(pida_pkg::MODE_INSERT, 0, 32'hffff_ffff);      // at the front
        send_op(pida_pkg::MODE_INSERT, 5, 32'h1111_1111);      // past the count
        send_op(pida_pkg::MODE_INSERT, POS_MAX, 32'h2222_2222);
        send_op(pida_pkg::MODE_INSERT, 4, 32'h0000_0001);
        send_op(pida_pkg::MODE_READ, 0, 32'h0);
        send_op(pida_pkg::MODE_READ, 4, 32'h0);
        send_op(pida_pkg::MODE_READ, 5, 32'h0);
        send_op(pida_pkg::MODE_READ, 2, 32'h0);
        send_op(MODE_UNUSED, POS_MAX, 32'hffff_ffff);
        send_op(pida_pkg::MODE_DELETE, 2, 32'h0);
        send_op(pida_pkg::MODE_DELETE, 3, 32'h0);              // last entry
        send_op(pida_pkg::MODE_DELETE, 3, 32'h0);              // now past the count
        send_op(pida_pkg::MODE_DELETE, 0, 32'h0);
        send_op(pida_pkg::MODE_DELETE, DEPTH, 32'h0);
        wait_drained();
    endtask

    task automatic test_fill_drain();
        while (shadow_count < DEPTH)
            send_op(pida_pkg::MODE_INSERT, $urandom_range(shadow_count), rand_value());
        send_op(pida_pkg::MODE_INSERT, 0, rand_value());
        send_op(pida_pkg::MODE_INSERT, DEPTH, rand_value());   // full, at the end position
        send_op(pida_pkg::MODE_INSERT, POS_MAX, rand_value());
        send_op(pida_pkg::MODE_READ, DEPTH - 1, 32'h0);
        send_op(pida_pkg::MODE_READ, DEPTH, 32'h0);
        send_op(pida_pkg::MODE_DELETE, DEPTH - 1, 32'h0);
        send_op(pida_pkg::MODE_INSERT, DEPTH - 1, rand_value());
        while (shadow_count > 0)
            send_op(pida_pkg::MODE_DELETE, $urandom_range(shadow_count - 1), rand_value());
        send_op(pida_pkg::MODE_DELETE, 0, 32'h0);
        wait_drained();
    endtask

    // receiver holds off long enough for the input side to back up
    task automatic test_backpressure();
        hold_left = 300;
        repeat (20) send_word(rand_word(1'b1));
        wait_drained();
    endtask

    task automatic test_random(input int n);
        bit grow;
        grow = 1'b1;
        repeat (n) begin
            if (shadow_count == DEPTH) grow = 1'b0;
            else if (shadow_count == 0) grow = 1'b1;
            else if ($urandom_range(99) == 0) grow = ~grow;
            send_word(rand_word(grow));
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct   = 31;
        out_stall_pct = 85;
        test_empty_list();
        test_edges();
        test_fill_drain();
        test_backpressure();
        test_random(200);

        in_idle_pct   = 85;
        out_stall_pct = 31;
        test_fill_drain();
        test_random(200);

        in_idle_pct   = 0;
        out_stall_pct = 0;
        test_backpressure();
        test_random(260);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pida_pkg.sv
rtl/core/pida_ctrl.sv
rtl/core/pida_datapath.sv
rtl/core/positional_insert_delete_array.sv
rtl/core/pida_checker.sv
tb/tb_positional_insert_delete_array.sv
